// ----- rtl/whht_pkg.sv -----
// ----------------------------------------------------------------------------
// whht_pkg
// Shared widths, register indexes, command/status types and the saturating
// adder for the weighted heavy-hitter table.
// ----------------------------------------------------------------------------
package whht_pkg;

   localparam int KEY_W    = 32;
   localparam int CNT_W    = 32;
   localparam int WGT_W    = 16;
   localparam int TIU_W    = 9;
   localparam int KEEP_W   = 8;
   localparam int BUDGET_W = 10;
   localparam int CSR_W    = 9;

   localparam logic CSR_TABLE_IN_USE = 1'b0;
   localparam logic CSR_KEEP_COUNT   = 1'b1;

   localparam logic [TIU_W-1:0]  TIU_RESET  = 9'd256;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 8'd64;

   localparam logic ACT_UPDATE = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   typedef struct packed {
      logic latch_req;
      logic srch_rd;
      logic srch_cmp;
      logic decide;
      logic ev_start;
      logic out_rd;
      logic out_lat;
      logic in_rd;
      logic in_cmp;
      logic apply;
      logic cp_rd;
      logic cp_wr;
      logic ev_end;
      logic insert;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic total_zero;
      logic match;
      logic srch_last;
      logic need_evict;
      logic is_miss_update;
      logic rank_en;
      logic m_zero;
      logic j_last;
      logic i_last;
      logic rank_ok;
      logic slot_free;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

endpackage

// ----- rtl/whht_ctrl.sv -----
// ----------------------------------------------------------------------------
// whht_ctrl
// Sequencer for lookup, update, insert and the rank-select eviction.
// ----------------------------------------------------------------------------
module whht_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  whht_pkg::status_type  status,
   output whht_pkg::cmd_type     cmd
);
   import whht_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SRCH_RD  = 4'd1;
   localparam logic [3:0] S_SRCH_CMP = 4'd2;
   localparam logic [3:0] S_DECIDE   = 4'd3;
   localparam logic [3:0] S_EV_START = 4'd4;
   localparam logic [3:0] S_OUT_RD   = 4'd5;
   localparam logic [3:0] S_OUT_LAT  = 4'd6;
   localparam logic [3:0] S_IN_RD    = 4'd7;
   localparam logic [3:0] S_IN_CMP   = 4'd8;
   localparam logic [3:0] S_APPLY    = 4'd9;
   localparam logic [3:0] S_CP_RD    = 4'd10;
   localparam logic [3:0] S_CP_WR    = 4'd11;
   localparam logic [3:0] S_EV_END   = 4'd12;
   localparam logic [3:0] S_INSERT   = 4'd13;
   localparam logic [3:0] S_DONE     = 4'd14;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in = status.total_zero ? S_DECIDE : S_SRCH_RD;
            end
         end
         S_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            state_in = S_SRCH_CMP;
         end
         S_SRCH_CMP: begin
            cmd.srch_cmp = 1'b1;
            if (status.match || status.srch_last) state_in = S_DECIDE;
            else state_in = S_SRCH_RD;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (status.need_evict) state_in = S_EV_START;
            else if (status.is_miss_update) state_in = S_INSERT;
            else state_in = S_DONE;
         end
         S_EV_START: begin
            cmd.ev_start = 1'b1;
            state_in = status.rank_en ? S_OUT_RD : S_APPLY;
         end
         S_OUT_RD: begin
            cmd.out_rd = 1'b1;
            state_in = S_OUT_LAT;
         end
         S_OUT_LAT: begin
            cmd.out_lat = 1'b1;
            state_in = S_IN_RD;
         end
         S_IN_RD: begin
            cmd.in_rd = 1'b1;
            state_in = S_IN_CMP;
         end
         S_IN_CMP: begin
            cmd.in_cmp = 1'b1;
            if (!status.j_last) state_in = S_IN_RD;
            else if (status.rank_ok || status.i_last) state_in = S_APPLY;
            else state_in = S_OUT_RD;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in = status.m_zero ? S_EV_END : S_CP_RD;
         end
         S_CP_RD: begin
            cmd.cp_rd = 1'b1;
            state_in = S_CP_WR;
         end
         S_CP_WR: begin
            cmd.cp_wr = 1'b1;
            state_in = status.i_last ? S_EV_END : S_CP_RD;
         end
         S_EV_END: begin
            cmd.ev_end = 1'b1;
            state_in = S_INSERT;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ----- rtl/whht_datapath.sv -----
// ----------------------------------------------------------------------------
// whht_datapath
// Key/count memories, table bookkeeping, rank counters and result register.
// ----------------------------------------------------------------------------
module whht_datapath #(
   parameter int CAPACITY = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic                         csr_index,
   input  logic [whht_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                         req_action,
   input  logic [whht_pkg::KEY_W-1:0]   req_key,
   input  logic [whht_pkg::WGT_W-1:0]   req_weight,
   input  whht_pkg::cmd_type            cmd,
   output whht_pkg::status_type         status,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [whht_pkg::CNT_W-1:0]   rsp_estimate,
   output logic                         rsp_found,
   output logic [whht_pkg::CNT_W-1:0]   rsp_error_bound
);
   import whht_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = IW + 1;
   // The rank arithmetic must hold both the entry count and the keep count.
   localparam int KW = (IW + 2 > KEEP_W + 1) ? IW + 2 : KEEP_W + 1;
   localparam int LW = CW + KEEP_W;

   logic [KEY_W-1:0] key_mem [CAPACITY];
   logic [CNT_W-1:0] cnt_mem [CAPACITY];

   logic [KEY_W-1:0]    rd_key_a_ff;
   logic [CNT_W-1:0]    rd_cnt_a_ff, rd_cnt_b_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [WGT_W-1:0]    weight_ff;
   logic                action_ff, hit_ff, rank_en_ff;
   logic [CW-1:0]       idx_ff, total_ff, m_ff, i_ff, j_ff, w_ff, lt_ff, le_ff;
   logic [KW-1:0]       k_ff;
   logic [CNT_W-1:0]    est_ff, floor_ff, cand_ff, first_ff, sel_ff;
   logic [BUDGET_W-1:0] budget_ff;
   logic [TIU_W-1:0]    tiu_ff;
   logic [KEEP_W-1:0]   keep_ff;

   logic [CW-1:0]       idx_nx_in, i_nx_in, j_nx_in, lt_in, le_in;
   logic [KW-1:0]       m_ext, k_raw_in, k_in;
   logic [CNT_W-1:0]    upd_in, miss_in, wgt_ext;
   logic [LW-1:0]       lim_in, tiu_ext;
   logic [BUDGET_W-1:0] budget_in;
   logic                rank_ok_in, table_full;
   logic [IW-1:0]       ra, wa;
   logic                we;
   logic [KEY_W-1:0]    wkey;
   logic [CNT_W-1:0]    wcnt;

   assign idx_nx_in = idx_ff + CW'(1);
   assign i_nx_in   = i_ff + CW'(1);
   assign j_nx_in   = j_ff + CW'(1);
   assign wgt_ext   = CNT_W'(weight_ff);
   assign upd_in    = sat_add(rd_cnt_a_ff, wgt_ext);
   assign miss_in   = sat_add(wgt_ext, floor_ff);
   assign table_full = (total_ff >= CW'(CAPACITY));

   assign m_ext    = KW'(total_ff);
   assign k_raw_in = m_ext + KW'(1) - KW'(keep_ff);
   assign k_in     = (k_raw_in >= m_ext) ? (m_ext - KW'(1)) : k_raw_in;

   assign lt_in = lt_ff + CW'(rd_cnt_b_ff < cand_ff);
   assign le_in = le_ff + CW'(rd_cnt_b_ff <= cand_ff);
   assign rank_ok_in = (KW'(lt_in) <= k_ff) && (k_ff < KW'(le_in));

   assign tiu_ext   = LW'(tiu_ff);
   assign lim_in    = (LW'(m_ff) < LW'(keep_ff)) ? LW'(m_ff) : LW'(keep_ff);
   assign budget_in = (tiu_ext > lim_in) ? BUDGET_W'(tiu_ext - lim_in) : '0;

   always_comb begin
      status.total_zero     = (total_ff == '0);
      status.match          = (rd_key_a_ff == key_ff);
      status.srch_last      = (idx_nx_in == total_ff);
      status.is_miss_update = (action_ff == ACT_UPDATE) && !hit_ff;
      status.need_evict     = status.is_miss_update && ((budget_ff == '0) || table_full);
      status.rank_en        = (total_ff != '0) && ((m_ext + KW'(1)) >= KW'(keep_ff));
      status.m_zero         = (m_ff == '0);
      status.j_last         = (j_nx_in == m_ff);
      status.i_last         = (i_nx_in == m_ff);
      status.rank_ok        = rank_ok_in;
      status.slot_free      = !rsp_valid || rsp_ready;
   end

   // Single write port shared by the hit update, the insert and compaction.
   always_comb begin
      ra   = cmd.srch_rd ? idx_ff[IW-1:0] : i_ff[IW-1:0];
      we   = 1'b0;
      wa   = idx_ff[IW-1:0];
      wkey = key_ff;
      wcnt = upd_in;
      if (cmd.decide && hit_ff && (action_ff == ACT_UPDATE)) begin
         we = 1'b1;
      end else if (cmd.insert && !table_full) begin
         we   = 1'b1;
         wa   = total_ff[IW-1:0];
         wcnt = est_ff;
      end else if (cmd.cp_wr && (rd_cnt_a_ff > floor_ff)) begin
         we   = 1'b1;
         wa   = w_ff[IW-1:0];
         wkey = rd_key_a_ff;
         wcnt = rd_cnt_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[wa] <= wkey;
         cnt_mem[wa] <= wcnt;
      end
      if (cmd.srch_rd || cmd.out_rd || cmd.cp_rd) begin
         rd_key_a_ff <= key_mem[ra];
         rd_cnt_a_ff <= cnt_mem[ra];
      end
      if (cmd.in_rd) rd_cnt_b_ff <= cnt_mem[j_ff[IW-1:0]];
   end

   // Working registers without reset.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         key_ff    <= req_key;
         weight_ff <= req_weight;
         action_ff <= req_action;
         hit_ff    <= 1'b0;
         idx_ff    <= '0;
      end
      if (cmd.srch_cmp) begin
         if (status.match) hit_ff <= 1'b1;
         else idx_ff <= idx_nx_in;
      end
      if (cmd.decide) begin
         if (hit_ff) est_ff <= (action_ff == ACT_UPDATE) ? upd_in : rd_cnt_a_ff;
         else est_ff <= (action_ff == ACT_UPDATE) ? miss_in : floor_ff;
      end
      if (cmd.ev_start) begin
         m_ff       <= total_ff;
         k_ff       <= k_in;
         rank_en_ff <= status.rank_en;
         i_ff       <= '0;
      end
      if (cmd.out_lat) begin
         cand_ff <= rd_cnt_a_ff;
         if (i_ff == '0) first_ff <= rd_cnt_a_ff;
         j_ff  <= '0;
         lt_ff <= '0;
         le_ff <= '0;
      end
      if (cmd.in_cmp) begin
         lt_ff <= lt_in;
         le_ff <= le_in;
         j_ff  <= j_nx_in;
         if (status.j_last) begin
            if (rank_ok_in) sel_ff <= cand_ff;
            else if (status.i_last) sel_ff <= first_ff;
            else i_ff <= i_nx_in;
         end
      end
      if (cmd.apply) begin
         i_ff <= '0;
         w_ff <= '0;
      end
      if (cmd.cp_wr) begin
         i_ff <= i_nx_in;
         if (rd_cnt_a_ff > floor_ff) w_ff <= w_ff + CW'(1);
      end
      if (cmd.emit) begin
         rsp_estimate    <= est_ff;
         rsp_found       <= hit_ff;
         rsp_error_bound <= floor_ff;
      end
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tiu_ff    <= TIU_RESET;
         keep_ff   <= KEEP_RESET;
         total_ff  <= '0;
         budget_ff <= BUDGET_W'(TIU_RESET);
         floor_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_TABLE_IN_USE) tiu_ff <= csr_wdata[TIU_W-1:0];
            else keep_ff <= csr_wdata[KEEP_W-1:0];
         end
         if (cmd.apply && rank_en_ff && (sel_ff > floor_ff)) floor_ff <= sel_ff;
         if (cmd.ev_end) begin
            total_ff  <= w_ff;
            budget_ff <= budget_in;
         end
         if (cmd.insert) begin
            if (!table_full) total_ff <= total_ff + CW'(1);
            if (budget_ff != '0) budget_ff <= budget_ff - BUDGET_W'(1);
         end
         if (cmd.emit) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

endmodule

// ----- rtl/weighted_heavy_hitter_table.sv -----
// ----------------------------------------------------------------------------
// weighted_heavy_hitter_table
// Keyed weighted frequency table with rank-based batch eviction.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    action, key, weight
//   rsp      out        rsp_valid/rsp_ready    estimate, found, error_bound
//   csr      in         csr_valid/csr_ready    index, wdata
//
// A query or an update scans the stored entries by a sequential key search
// over the single read port of the key memory, and a miss update then
// inserts its key. An eviction comes first where needed: rank selection
// with candidates tried in turn, then compaction of the entries held.
// Reset is synchronous; the tables need no clearing pass. Register writes are
// taken only while the sequencer is idle.
// One result register lets the next transfer be accepted while a result waits.
// ----------------------------------------------------------------------------
module weighted_heavy_hitter_table #(
   parameter int CAPACITY = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_action,
   input  logic [whht_pkg::KEY_W-1:0]  req_key,
   input  logic [whht_pkg::WGT_W-1:0]  req_weight,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [whht_pkg::CNT_W-1:0]  rsp_estimate,
   output logic                        rsp_found,
   output logic [whht_pkg::CNT_W-1:0]  rsp_error_bound,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_index,
   input  logic [whht_pkg::CSR_W-1:0]  csr_wdata
);
   import whht_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = req_ready;

   whht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   whht_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_weight      (req_weight),
      .cmd             (cmd),
      .status          (status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_estimate    (rsp_estimate),
      .rsp_found       (rsp_found),
      .rsp_error_bound (rsp_error_bound)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a transfer was in progress");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.emit))
      else $error("result raised without an emit command");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
`endif

endmodule
